// ----- src/ev_charger_sequencer_unit_defines.svh -----
// Assertion macros shared by the charger sequencer RTL.
`ifndef EV_CHARGER_SEQUENCER_UNIT_DEFINES_SVH
`define EV_CHARGER_SEQUENCER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock once reset is released.
`define ECS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("ecs assertion failed");
// Check that a condition implies another in the following cycle.
`define ECS_ASSERT_NEXT(lbl, cause, effect) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cause) |=> (effect)) \
        else $error("ecs assertion failed");
`else
`define ECS_ASSERT(lbl, prop)
`define ECS_ASSERT_NEXT(lbl, cause, effect)
`endif

`endif

// ----- src/ecs_pkg.sv -----
// Types and constants of the charger sequencer.
package ecs_pkg;

    localparam logic [28:0] ID_BATTERY  = 29'h389;
    localparam logic [28:0] ID_PILOT    = 29'h38A;
    localparam logic [10:0] ID_EVSE     = 11'h285;
    localparam logic [10:0] ID_SETPOINT = 11'h286;

    localparam logic [7:0]  EVSE_REQ_START   = 8'h03;
    localparam logic [7:0]  EVSE_REQ_STAGE1  = 8'h16;
    localparam logic [7:0]  EVSE_REQ_CHARGE  = 8'hB6;
    localparam logic [7:0]  EVSE_BYTE3       = 8'h09;
    localparam logic [7:0]  EVSE_BYTE6_IDLE  = 8'h08;
    localparam logic [7:0]  FRAME_TRAILER    = 8'h0A;
    localparam logic [7:0]  SETPOINT_BYTE3   = 8'd51;

    localparam logic [3:0]  SUBTICK_SETPOINT = 4'd5;
    localparam logic [3:0]  SUBTICK_LAST     = 4'd10;
    localparam logic [3:0]  HB_DIV_LAST      = 4'd10;
    localparam logic [15:0] TIMER_MAX        = 16'hFFFF;

    // Configuration register indexes
    localparam logic [2:0] CFG_PROX_CONNECTED = 3'd0;
    localparam logic [2:0] CFG_PROX_PRESSED   = 3'd1;
    localparam logic [2:0] CFG_FULL_BATTERY   = 3'd2;
    localparam logic [2:0] CFG_VOLT_SETPOINT  = 3'd3;
    localparam logic [2:0] CFG_CURR_SETPOINT  = 3'd4;
    localparam logic [2:0] CFG_STAGE_DELAY    = 3'd5;

    localparam logic [1:0] PROX_OPEN      = 2'd0;
    localparam logic [1:0] PROX_PRESSED   = 2'd1;
    localparam logic [1:0] PROX_CONNECTED = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_INIT        = 4'd1,
        PH_STAGE1      = 4'd2,
        PH_STAGE2      = 4'd3,
        PH_CC          = 4'd4,
        PH_CV          = 4'd5,
        PH_COMPLETE    = 4'd6,
        PH_WAIT_DISCON = 4'd7,
        PH_FINISHED    = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        CMD_RX_OTHER = 2'd0,
        CMD_RX_BATT  = 2'd1,
        CMD_RX_PILOT = 2'd2,
        CMD_TICK     = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        logic        action;
        logic [28:0] frame_ident;
        logic [31:0] frame_low_word;
        logic [11:0] prox_sample;
    } t_in_item;

    typedef struct packed {
        logic        frame_valid;
        logic [10:0] out_ident;
        logic [63:0] out_payload;
        logic        precharge_level;
        logic        accepted;
        logic [3:0]  charge_phase;
        logic [8:0]  battery_volts;
        logic [7:0]  supply_volts;
        logic [7:0]  pilot_status;
        logic [15:0] alive_count;
    } t_out_item;

    // Classified request handed from front to back
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte3;
        logic [11:0] prox;
    } t_cmd;

endpackage

// ----- src/ecs_front.sv -----
// Front end: classifies input requests and queues them for the back end.
`include "ev_charger_sequencer_unit_defines.svh"

module ecs_front
    import ecs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_item,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_cmd       cmd_in;
    logic       push_ok;
    logic       pop_ok;

    always_comb begin
        cmd_in.byte0 = i_item.frame_low_word[7:0];
        cmd_in.byte1 = i_item.frame_low_word[15:8];
        cmd_in.byte3 = i_item.frame_low_word[31:24];
        cmd_in.prox  = i_item.prox_sample;
        if (i_item.action) begin
            cmd_in.kind = CMD_TICK;
        end else if (i_item.frame_ident == ID_BATTERY) begin
            cmd_in.kind = CMD_RX_BATT;
        end else if (i_item.frame_ident == ID_PILOT) begin
            cmd_in.kind = CMD_RX_PILOT;
        end else begin
            cmd_in.kind = CMD_RX_OTHER;
        end
    end

    assign full        = (r_count == 2'd2);
    assign push_ok     = push && !full;
    assign o_cmd_valid = (r_count != 2'd0);
    assign pop_ok      = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 2'd1;
        end else if (!push_ok && pop_ok) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push_ok) begin
                r_wptr <= ~r_wptr;
            end
            if (pop_ok) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= cmd_in;
        end
    end

    `ECS_ASSERT(a_front_count_bound, r_count <= 2'd2)
    `ECS_ASSERT_NEXT(a_front_push_grows, push_ok && !pop_ok, r_count == $past(r_count) + 2'd1)

endmodule

// ----- src/ecs_back.sv -----
// Back end: charger state, sequencer step, frame build and result queue.
`include "ev_charger_sequencer_unit_defines.svh"

module ecs_back
    import ecs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_item
);

    // Configuration
    logic [11:0] r_prox_conn_lim;
    logic [11:0] r_prox_press_lim;
    logic [8:0]  r_full_batt;
    logic [12:0] r_volt_set;
    logic [7:0]  r_curr_set;
    logic [15:0] r_stage_delay;

    // Charger state
    logic [8:0]  r_battery,   n_battery;
    logic [7:0]  r_supply,    n_supply;
    logic [7:0]  r_pilot,     n_pilot;
    logic [15:0] r_alive,     n_alive;
    logic        r_toggle,    n_toggle;
    logic [3:0]  r_subtick,   n_subtick;
    logic [3:0]  r_hb_div,    n_hb_div;
    logic [4:0]  r_heartbeat, n_heartbeat;
    t_phase      r_phase,     n_phase;
    t_phase      r_prev_phase, n_prev_phase;
    logic [15:0] r_stage_timer, n_stage_timer;
    logic [7:0]  r_evse_req,  n_evse_req;
    logic [12:0] r_volt_tgt,  n_volt_tgt;
    logic [7:0]  r_curr_tgt,  n_curr_tgt;

    // Result queue
    t_out_item   r_oq [2];
    logic        r_owptr;
    logic        r_orptr;
    logic [1:0]  r_ocount;
    logic [1:0]  n_ocount;

    logic        do_exec;
    logic        out_pop;
    logic [1:0]  prox_state;
    logic        advance;
    logic [16:0] volt_x10;
    logic [63:0] payload;
    logic [10:0] ident;
    logic        frame_valid;
    logic        accepted;
    t_out_item   result;

    assign do_exec   = i_cmd_valid && (r_ocount != 2'd2);
    assign o_cmd_pop = do_exec;
    assign empty     = (r_ocount == 2'd0);
    assign out_pop   = pop && !empty;
    assign o_item    = r_oq[r_orptr];

    assign volt_x10 = ({4'b0, r_volt_tgt} << 3) + ({4'b0, r_volt_tgt} << 1);
    assign advance  = (r_stage_timer > r_stage_delay);

    always_comb begin
        if (i_cmd.prox < r_prox_conn_lim) begin
            prox_state = PROX_CONNECTED;
        end else if (i_cmd.prox < r_prox_press_lim) begin
            prox_state = PROX_PRESSED;
        end else begin
            prox_state = PROX_OPEN;
        end
    end

    always_comb begin
        n_battery     = r_battery;
        n_supply      = r_supply;
        n_pilot       = r_pilot;
        n_alive       = r_alive;
        n_toggle      = r_toggle;
        n_subtick     = r_subtick;
        n_hb_div      = r_hb_div;
        n_heartbeat   = r_heartbeat;
        n_phase       = r_phase;
        n_prev_phase  = r_prev_phase;
        n_stage_timer = r_stage_timer;
        n_evse_req    = r_evse_req;
        n_volt_tgt    = r_volt_tgt;
        n_curr_tgt    = r_curr_tgt;
        payload       = '0;
        ident         = '0;
        frame_valid   = 1'b0;
        accepted      = 1'b0;

        case (i_cmd.kind)
            CMD_RX_BATT: begin
                n_battery = {i_cmd.byte0, 1'b0};
                n_supply  = i_cmd.byte1;
                n_alive   = r_alive + 16'd1;
                accepted  = 1'b1;
            end
            CMD_RX_PILOT: begin
                n_pilot  = i_cmd.byte3;
                n_alive  = r_alive + 16'd1;
                accepted = 1'b1;
            end
            CMD_TICK: begin
                n_toggle    = ~r_toggle;
                frame_valid = 1'b1;
                // Frame reflects state before this tick's sequencer step
                if (r_subtick == SUBTICK_SETPOINT) begin
                    ident   = ID_SETPOINT;
                    payload = {8'h00, FRAME_TRAILER, 8'h00, 8'h00,
                               SETPOINT_BYTE3, r_curr_tgt,
                               volt_x10[7:0], volt_x10[15:8]};
                end else begin
                    ident   = ID_EVSE;
                    payload = {FRAME_TRAILER,
                               (r_evse_req == EVSE_REQ_CHARGE) ? 8'h00 : EVSE_BYTE6_IDLE,
                               8'h00, {3'b000, r_heartbeat},
                               EVSE_BYTE3, r_evse_req, 8'h00, 8'h00};
                end

                if (r_subtick > SUBTICK_LAST) begin
                    n_subtick = 4'd0;
                    if (r_hb_div < HB_DIV_LAST) begin
                        n_hb_div = r_hb_div + 4'd1;
                    end else begin
                        n_hb_div    = 4'd0;
                        n_heartbeat = r_heartbeat + 5'd1;
                    end

                    case (r_phase)
                        PH_IDLE: begin
                            if (prox_state == PROX_PRESSED) begin
                                n_phase    = PH_INIT;
                                n_evse_req = EVSE_REQ_START;
                            end
                        end
                        PH_INIT: begin
                            if (advance) begin
                                n_phase    = PH_STAGE1;
                                n_evse_req = EVSE_REQ_STAGE1;
                            end
                        end
                        PH_STAGE1: begin
                            if (advance) begin
                                n_phase    = PH_STAGE2;
                                n_evse_req = EVSE_REQ_CHARGE;
                            end
                        end
                        PH_STAGE2: begin
                            if (advance) begin
                                n_phase    = PH_CC;
                                n_curr_tgt = r_curr_set;
                                n_volt_tgt = r_volt_set;
                            end
                        end
                        PH_CC: begin
                            // Full battery wins over a released button
                            if (r_battery > r_full_batt) begin
                                n_phase    = PH_COMPLETE;
                                n_curr_tgt = '0;
                                n_volt_tgt = '0;
                            end else if (prox_state != PROX_PRESSED) begin
                                n_phase    = PH_CV;
                                n_curr_tgt = '0;
                                n_volt_tgt = '0;
                            end
                        end
                        PH_CV: begin
                            n_phase = PH_COMPLETE;
                        end
                        PH_COMPLETE: begin
                            n_phase = PH_WAIT_DISCON;
                        end
                        PH_WAIT_DISCON: begin
                            if (prox_state == PROX_OPEN) begin
                                n_phase = PH_FINISHED;
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (r_stage_timer != TIMER_MAX) begin
                        n_stage_timer = r_stage_timer + 16'd1;
                    end
                    if (n_phase != r_prev_phase) begin
                        n_stage_timer = '0;
                    end
                    n_prev_phase = n_phase;
                end else begin
                    n_subtick = r_subtick + 4'd1;
                end
            end
            default: begin
            end
        endcase

        result.frame_valid     = frame_valid;
        result.out_ident       = ident;
        result.out_payload     = payload;
        result.precharge_level = n_toggle;
        result.accepted        = accepted;
        result.charge_phase    = n_phase;
        result.battery_volts   = n_battery;
        result.supply_volts    = n_supply;
        result.pilot_status    = n_pilot;
        result.alive_count     = n_alive;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prox_conn_lim  <= 12'd200;
            r_prox_press_lim <= 12'd400;
            r_full_batt      <= 9'd230;
            r_volt_set       <= 13'd240;
            r_curr_set       <= 8'd2;
            r_stage_delay    <= 16'd10;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_PROX_CONNECTED: r_prox_conn_lim  <= i_cfg_data[11:0];
                CFG_PROX_PRESSED:   r_prox_press_lim <= i_cfg_data[11:0];
                CFG_FULL_BATTERY:   r_full_batt      <= i_cfg_data[8:0];
                CFG_VOLT_SETPOINT:  r_volt_set       <= i_cfg_data[12:0];
                CFG_CURR_SETPOINT:  r_curr_set       <= i_cfg_data[7:0];
                CFG_STAGE_DELAY:    r_stage_delay    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_battery     <= '0;
            r_supply      <= '0;
            r_pilot       <= '0;
            r_alive       <= '0;
            r_toggle      <= 1'b0;
            r_subtick     <= '0;
            r_hb_div      <= '0;
            r_heartbeat   <= '0;
            r_phase       <= PH_IDLE;
            r_prev_phase  <= PH_IDLE;
            r_stage_timer <= '0;
            r_evse_req    <= '0;
            r_volt_tgt    <= '0;
            r_curr_tgt    <= '0;
        end else if (do_exec) begin
            r_battery     <= n_battery;
            r_supply      <= n_supply;
            r_pilot       <= n_pilot;
            r_alive       <= n_alive;
            r_toggle      <= n_toggle;
            r_subtick     <= n_subtick;
            r_hb_div      <= n_hb_div;
            r_heartbeat   <= n_heartbeat;
            r_phase       <= n_phase;
            r_prev_phase  <= n_prev_phase;
            r_stage_timer <= n_stage_timer;
            r_evse_req    <= n_evse_req;
            r_volt_tgt    <= n_volt_tgt;
            r_curr_tgt    <= n_curr_tgt;
        end
    end

    always_comb begin
        n_ocount = r_ocount;
        if (do_exec && !out_pop) begin
            n_ocount = r_ocount + 2'd1;
        end else if (!do_exec && out_pop) begin
            n_ocount = r_ocount - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owptr  <= 1'b0;
            r_orptr  <= 1'b0;
            r_ocount <= 2'd0;
        end else begin
            r_ocount <= n_ocount;
            if (do_exec) begin
                r_owptr <= ~r_owptr;
            end
            if (out_pop) begin
                r_orptr <= ~r_orptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_exec) begin
            r_oq[r_owptr] <= result;
        end
    end

    `ECS_ASSERT(a_back_count_bound, r_ocount <= 2'd2)
    `ECS_ASSERT(a_subtick_bound, r_subtick <= SUBTICK_LAST + 4'd1)
    `ECS_ASSERT_NEXT(a_timer_clear, do_exec && (n_phase != r_phase), r_stage_timer == 16'd0)

endmodule

// ----- src/ev_charger_sequencer_unit.sv -----
// Top level of the onboard charger sequencer.
//
// Usage: requests enter through a queue-style port (push / full) and results
// leave through another (empty / pop). Every request yields exactly one
// result, in order. A receive request latches battery, supply or pilot data
// from the two charger identifiers; a tick request toggles precharge, builds
// one outgoing frame and every twelfth tick steps the charge sequencer.
// A request passes through the front queue, then back-end execution into the
// result queue. Throughput: one request per cycle while the receiver keeps
// popping; both internal queues hold two entries so push and pop may run every
// cycle. Configuration is written on the plain write port; the user must write
// it only while the block is idle, the block itself does not enforce this.
// Reset (synchronous, active low) empties both queues, loads the default
// limits and setpoints and puts the sequencer in the idle phase.
// When the receiver stops popping, the result queue fills, the back end holds,
// the front queue fills and full rises; no request or result is dropped.
`include "ev_charger_sequencer_unit_defines.svh"

module ev_charger_sequencer_unit
    import ecs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_item,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    ecs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    ecs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_item)
    );

    `ECS_ASSERT_NEXT(a_full_blocks_exec, full && !cmd_pop, full)

endmodule

// ----- tb/ev_charger_sequencer_unit_chk.sv -----
// Checker for the charger sequencer: mirrors the configuration, predicts each status and compares.
module ev_charger_sequencer_unit_chk
    import ecs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  t_in_item    i_req,
    input  logic        i_empty,
    input  logic        i_pop,
    input  t_out_item   i_status,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // configuration copy
    logic [11:0] conn_lim;
    logic [11:0] press_lim;
    logic [8:0]  full_lim;
    logic [12:0] volt_set;
    logic [7:0]  curr_set;
    logic [15:0] delay_lim;

    // charger state copy
    logic [8:0]  battery_v;
    logic [7:0]  supply_v;
    logic [7:0]  pilot_b;
    logic [15:0] alive_cnt;
    logic        precharge;
    logic [3:0]  subtick;
    logic [3:0]  hb_div;
    logic [4:0]  hb;
    t_phase      phase;
    t_phase      last_phase;
    logic [15:0] stage_tmr;
    logic [7:0]  evse_req;
    logic [12:0] volt_tgt;
    logic [7:0]  curr_tgt;

    t_out_item   status_q[$];

    task automatic reset_charger();
        conn_lim   = 12'd200;
        press_lim  = 12'd400;
        full_lim   = 9'd230;
        volt_set   = 13'd240;
        curr_set   = 8'd2;
        delay_lim  = 16'd10;
        battery_v  = '0;
        supply_v   = '0;
        pilot_b    = '0;
        alive_cnt  = '0;
        precharge  = 1'b0;
        subtick    = '0;
        hb_div     = '0;
        hb         = '0;
        phase      = PH_IDLE;
        last_phase = PH_IDLE;
        stage_tmr  = '0;
        evse_req   = '0;
        volt_tgt   = '0;
        curr_tgt   = '0;
    endtask

    function automatic logic [63:0] setpoint_payload();
        logic [15:0] volts_x10;
        volts_x10 = {3'b000, volt_tgt} * 16'd10;
        return {8'h00, FRAME_TRAILER, 8'h00, 8'h00, SETPOINT_BYTE3, curr_tgt,
                volts_x10[7:0], volts_x10[15:8]};
    endfunction

    function automatic logic [63:0] evse_payload();
        logic [7:0] mode_byte;
        mode_byte = (evse_req == EVSE_REQ_CHARGE) ? 8'h00 : EVSE_BYTE6_IDLE;
        return {FRAME_TRAILER, mode_byte, 8'h00, {3'b000, hb}, EVSE_BYTE3, evse_req,
                8'h00, 8'h00};
    endfunction

    task automatic sequencer_step(input logic [11:0] prox);
        logic       go;
        logic [1:0] plug;
        go = stage_tmr > delay_lim;
        if (hb_div < HB_DIV_LAST) begin
            hb_div++;
        end else begin
            hb_div = '0;
            hb++;
        end
        // connected limit is tested first even when the limits are out of order
        if (prox < conn_lim) plug = PROX_CONNECTED;
        else if (prox < press_lim) plug = PROX_PRESSED;
        else plug = PROX_OPEN;
        case (phase)
            PH_IDLE: begin
                if (plug == PROX_PRESSED) begin
                    phase    = PH_INIT;
                    evse_req = EVSE_REQ_START;
                end
            end
            PH_INIT: begin
                if (go) begin
                    evse_req = EVSE_REQ_STAGE1;
                    phase    = PH_STAGE1;
                end
            end
            PH_STAGE1: begin
                if (go) begin
                    evse_req = EVSE_REQ_CHARGE;
                    phase    = PH_STAGE2;
                end
            end
            PH_STAGE2: begin
                if (go) begin
                    curr_tgt = curr_set;
                    volt_tgt = volt_set;
                    phase    = PH_CC;
                end
            end
            PH_CC: begin
                // full battery wins over a released button
                if (plug != PROX_PRESSED) begin
                    phase    = PH_CV;
                    curr_tgt = '0;
                    volt_tgt = '0;
                end
                if (battery_v > full_lim) begin
                    phase    = PH_COMPLETE;
                    curr_tgt = '0;
                    volt_tgt = '0;
                end
            end
            PH_CV:          phase = PH_COMPLETE;
            PH_COMPLETE:    phase = PH_WAIT_DISCON;
            PH_WAIT_DISCON: if (plug == PROX_OPEN) phase = PH_FINISHED;
            default: ;
        endcase
        if (stage_tmr < TIMER_MAX) stage_tmr++;
        if (phase != last_phase) stage_tmr = '0;
        last_phase = phase;
    endtask

    task automatic advance_charger(input t_in_item req);
        t_out_item st;
        st = '0;
        if (req.action == 1'b0) begin
            if (req.frame_ident == ID_BATTERY) begin
                battery_v   = {req.frame_low_word[7:0], 1'b0};
                supply_v    = req.frame_low_word[15:8];
                alive_cnt++;
                st.accepted = 1'b1;
            end else if (req.frame_ident == ID_PILOT) begin
                pilot_b     = req.frame_low_word[31:24];
                alive_cnt++;
                st.accepted = 1'b1;
            end
        end else begin
            precharge      = ~precharge;
            st.frame_valid = 1'b1;
            if (subtick == SUBTICK_SETPOINT) begin
                st.out_ident   = ID_SETPOINT;
                st.out_payload = setpoint_payload();
            end else begin
                st.out_ident   = ID_EVSE;
                st.out_payload = evse_payload();
            end
            if (subtick > SUBTICK_LAST) begin
                sequencer_step(req.prox_sample);
                subtick = '0;
            end else begin
                subtick++;
            end
        end
        st.precharge_level = precharge;
        st.charge_phase    = phase;
        st.battery_volts   = battery_v;
        st.supply_volts    = supply_v;
        st.pilot_status    = pilot_b;
        st.alive_count     = alive_cnt;
        status_q.push_back(st);
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic compare_status(input t_out_item got);
        t_out_item want;
        if (status_q.size() == 0) begin
            $error("status popped with no request outstanding");
            o_fail_count++;
        end else begin
            want = status_q.pop_front();
            check_field("frame_valid", 64'(want.frame_valid), 64'(got.frame_valid));
            check_field("out_ident", 64'(want.out_ident), 64'(got.out_ident));
            check_field("out_payload", want.out_payload, got.out_payload);
            check_field("precharge_level", 64'(want.precharge_level),
                        64'(got.precharge_level));
            check_field("accepted", 64'(want.accepted), 64'(got.accepted));
            check_field("charge_phase", 64'(want.charge_phase), 64'(got.charge_phase));
            check_field("battery_volts", 64'(want.battery_volts), 64'(got.battery_volts));
            check_field("supply_volts", 64'(want.supply_volts), 64'(got.supply_volts));
            check_field("pilot_status", 64'(want.pilot_status), 64'(got.pilot_status));
            check_field("alive_count", 64'(want.alive_count), 64'(got.alive_count));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_charger();
            status_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_PROX_CONNECTED: conn_lim  = i_cfg_data[11:0];
                    CFG_PROX_PRESSED:   press_lim = i_cfg_data[11:0];
                    CFG_FULL_BATTERY:   full_lim  = i_cfg_data[8:0];
                    CFG_VOLT_SETPOINT:  volt_set  = i_cfg_data[12:0];
                    CFG_CURR_SETPOINT:  curr_set  = i_cfg_data[7:0];
                    CFG_STAGE_DELAY:    delay_lim = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) compare_status(i_status);
            if (i_push && !i_full) advance_charger(i_req);
        end
        o_pending = status_q.size();
    end

endmodule

// ----- tb/ev_charger_sequencer_unit_tb.sv -----
// Testbench top for the charger sequencer: clock, reset, request and pop traffic, verdict.
module ev_charger_sequencer_unit_tb;
    import ecs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         STALL_LIMIT   = 2000;
    localparam logic [2:0] CFG_SPARE_LOW  = 3'd6;
    localparam logic [2:0] CFG_SPARE_HIGH = 3'd7;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    t_in_item    i_item      = '0;
    logic        empty;
    logic        pop         = 1'b0;
    t_out_item   o_item;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_idx   = '0;
    logic [15:0] i_cfg_data  = '0;

    int pending;
    int fail_count;
    int quiet_cycles = 0;
    int conn_lim     = 200;
    int press_lim    = 400;
    bit calm         = 1'b0;

    ev_charger_sequencer_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_item     (o_item),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    ev_charger_sequencer_unit_chk chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_req       (i_item),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_status    (o_item),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // end the run when traffic stops moving
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("ev_charger_sequencer_unit test failed");
            $finish;
        end
    end

    // result side: random stall bursts, none once calm
    initial begin
        int rest;
        rest = 0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                pop <= 1'b1;
            end else if (rest > 0) begin
                pop <= 1'b0;
                rest--;
            end else if ($urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                rest = $urandom_range(0, 11);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic t_in_item make_req(input logic act, input logic [28:0] ident,
                                          input logic [31:0] word, input logic [11:0] prox);
        t_in_item req;
        req.action         = act;
        req.frame_ident    = ident;
        req.frame_low_word = word;
        req.prox_sample    = prox;
        return req;
    endfunction

    // proximity sample that classifies as the wanted plug state under the current limits, where they allow one
    function automatic logic [11:0] prox_for(input logic [1:0] goal);
        int hi_lim;
        hi_lim = (conn_lim > press_lim) ? conn_lim : press_lim;
        case (goal)
            PROX_CONNECTED: if (conn_lim > 0) return 12'($urandom_range(0, conn_lim - 1));
            PROX_PRESSED: begin
                if (press_lim > conn_lim)
                    return 12'($urandom_range(conn_lim, press_lim - 1));
            end
            default: return 12'($urandom_range(hi_lim, 4095));
        endcase
        return 12'($urandom);
    endfunction

    function automatic t_in_item random_request(input logic [1:0] goal, input int prox_noise);
        t_in_item req;
        int       pick;
        req.action         = 1'b1;
        req.frame_ident    = 29'($urandom);
        req.frame_low_word = $urandom;
        req.prox_sample    = 12'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            req.action      = 1'b0;
            req.frame_ident = ID_BATTERY;
        end else if (pick < 22) begin
            req.action      = 1'b0;
            req.frame_ident = ID_PILOT;
        end else if (pick < 27) begin
            // one bit away from a known identifier
            req.action      = 1'b0;
            req.frame_ident = (pick[0] ? ID_BATTERY : ID_PILOT) ^ (29'd1 << $urandom_range(0, 28));
        end else if (pick < 30) begin
            req.action = 1'b0;
        end else if ($urandom_range(1, 100) > prox_noise) begin
            req.prox_sample = prox_for(goal);
        end
        return req;
    endfunction

    task automatic send_request(input t_in_item req);
        if (!calm && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic run_requests(input int count, input logic [1:0] goal, input int prox_noise);
        repeat (count) send_request(random_request(goal, prox_noise));
    endtask

    // hold off until every status has come back
    task automatic settle();
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
    endtask

    task automatic load_limits(input logic [15:0] conn, input logic [15:0] press,
                               input logic [15:0] full_v, input logic [15:0] volt,
                               input logic [15:0] curr, input logic [15:0] delay_v);
        write_reg(CFG_PROX_CONNECTED, conn);
        write_reg(CFG_PROX_PRESSED, press);
        write_reg(CFG_FULL_BATTERY, full_v);
        write_reg(CFG_VOLT_SETPOINT, volt);
        write_reg(CFG_CURR_SETPOINT, curr);
        write_reg(CFG_STAGE_DELAY, delay_v);
        i_cfg_wr_en <= 1'b0;
        conn_lim  = int'(conn & 16'h0FFF);
        press_lim = int'(press & 16'h0FFF);
    endtask

    initial begin
        logic [15:0] volt_pick;
        logic [15:0] curr_pick;
        int          conn;
        int          press;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // receive frames: extremes, unknown and near-miss identifiers
        send_request(make_req(1'b0, ID_BATTERY, 32'h0000_0000, 12'h000));
        send_request(make_req(1'b0, ID_BATTERY, 32'hFFFF_FFFF, 12'hFFF));
        send_request(make_req(1'b0, ID_PILOT, 32'hFFFF_FFFF, 12'h000));
        send_request(make_req(1'b0, ID_PILOT, 32'h00FF_FFFF, 12'hFFF));
        send_request(make_req(1'b0, 29'h1FFF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
        send_request(make_req(1'b0, 29'h000_0000, 32'h0000_0000, 12'h000));
        send_request(make_req(1'b0, ID_BATTERY | 29'h1000_0000, 32'h5A5A_5A5A, 12'h000));
        send_request(make_req(1'b0, ID_BATTERY, 32'h1234_5678, 12'h000));
        // one full sub-tick round: setpoint frame, then a sequencer step with the button pressed
        for (int n = 0; n < 13; n++) begin
            send_request(make_req(1'b1, (n == 2) ? ID_BATTERY : 29'($urandom), $urandom,
                                  (n == 11) ? 12'd300 : (n[0] ? 12'hFFF : 12'h000)));
            if (n == 6) send_request(make_req(1'b0, ID_PILOT, 32'hA500_0000, 12'h000));
        end
        settle();

        // nearly every sample presses the button, no stage delay: climb to constant current
        case ($urandom_range(0, 3))
            0:       volt_pick = 16'd0;
            1:       volt_pick = 16'd6553;
            2:       volt_pick = 16'hFFFF;
            default: volt_pick = 16'($urandom_range(0, 6553));
        endcase
        case ($urandom_range(0, 2))
            0:       curr_pick = 16'd0;
            1:       curr_pick = 16'd255;
            default: curr_pick = 16'($urandom_range(0, 255));
        endcase
        load_limits(16'd0, 16'd4095, 16'd510, volt_pick, curr_pick, 16'd0);
        run_requests(300, PROX_PRESSED, 15);
        settle();

        // hold in constant current under a random ordered band
        conn  = $urandom_range(1, 2000);
        press = conn + $urandom_range(1, 2000);
        load_limits(16'(conn), 16'(press), 16'd510, 16'($urandom_range(0, 6553)),
                    16'($urandom_range(0, 255)), 16'hFFFF);
        run_requests(400, PROX_PRESSED, 0);
        settle();

        // leave constant current by a full battery or by releasing, then unplug
        conn  = $urandom_range(0, 2000);
        press = conn + $urandom_range(1, 2000);
        if ($urandom_range(0, 1) == 1) begin
            load_limits(16'(conn), 16'(press), 16'($urandom_range(0, 200)),
                        16'($urandom_range(0, 6553)), 16'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)));
            run_requests(150, PROX_PRESSED, 0);
        end else begin
            load_limits(16'(conn), 16'(press), 16'd510, 16'($urandom_range(0, 6553)),
                        16'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            run_requests(150, PROX_OPEN, 0);
        end
        run_requests(150, PROX_OPEN, 10);
        settle();

        // out-of-order limits, wide values masked, spare indexes ignored
        write_reg(CFG_SPARE_LOW, 16'($urandom));
        write_reg(CFG_SPARE_HIGH, 16'($urandom));
        load_limits(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'($urandom));
        run_requests(380, PROX_OPEN, 50);
        calm = 1'b1;
        run_requests(150, PROX_CONNECTED, 50);
        settle();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ev_charger_sequencer_unit test passed");
        end else begin
            $display("ev_charger_sequencer_unit test failed");
        end
        $finish;
    end

endmodule
